### rtl/lhc_pkg.sv
// Shared types, constants and state encoding for the layered hit clustering block.
`default_nettype none

package lhc_pkg;

    // Store and geometry
    localparam int MAX_HITS   = 64;
    localparam int NUM_LAYERS = 6;
    localparam int IDX_W      = $clog2(MAX_HITS);
    localparam int CNT_W      = $clog2(MAX_HITS + 1);
    localparam int LAYER_W    = 3;
    localparam int X_W        = 7;
    localparam int LBL_W      = 7;
    localparam int CHAIN_DEPTH = NUM_LAYERS - 1;
    localparam int CHAIN_W    = $clog2(NUM_LAYERS);
    localparam int LIMIT_W    = X_W + $clog2(NUM_LAYERS);
    localparam int HIT_W      = LAYER_W + X_W;

    // Configuration port
    localparam int EPS_W      = 7;
    localparam int MINP_W     = 3;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_EPS        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 1'd1;
    localparam logic [EPS_W-1:0]  EPS_RESET  = 7'd2;
    localparam logic [MINP_W-1:0] MINP_RESET = 3'd4;

    // Label codes
    localparam logic signed [LBL_W-1:0] LBL_FREE  = -7'sd2;
    localparam logic signed [LBL_W-1:0] LBL_NOISE = -7'sd1;

    // Input transaction
    typedef struct packed {
        logic [LAYER_W-1:0] layer;
        logic [X_W-1:0]     xpos;
        logic               final_hit;
    } hit_in_t;

    // Output transaction
    typedef struct packed {
        logic signed [LBL_W-1:0] cluster_label;
        logic                    last_label;
        logic                    overflowed;
    } label_out_t;

    // Control of the shared match unit
    typedef struct packed {
        logic clear;
        logic sample;
    } match_ctrl_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_RD,
        ST_SEED_CHK,
        ST_SCAN,
        ST_LABEL,
        ST_SEED_NEXT,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } state_t;

endpackage

`default_nettype wire

### rtl/lhc_ram.sv
// Generic single write port, single registered read port RAM.
`default_nettype none

module lhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/lhc_match.sv
// Shared distance/compare unit that tracks the nearest free hit of one layer scan.
`default_nettype none

module lhc_match (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lhc_pkg::match_ctrl_t            ctrl,
    input  wire logic [lhc_pkg::IDX_W-1:0]       cand_idx,
    input  wire logic [lhc_pkg::LAYER_W-1:0]     cand_layer,
    input  wire logic [lhc_pkg::X_W-1:0]         cand_x,
    input  wire logic signed [lhc_pkg::LBL_W-1:0] cand_label,
    input  wire logic [lhc_pkg::LAYER_W-1:0]     want_layer,
    input  wire logic [lhc_pkg::X_W-1:0]         qx,
    input  wire logic [lhc_pkg::LIMIT_W-1:0]     limit,
    output logic                                 found,
    output logic [lhc_pkg::IDX_W-1:0]            best_idx,
    output logic [lhc_pkg::X_W-1:0]              best_x
);

    logic                      found_reg;
    logic [lhc_pkg::IDX_W-1:0] best_idx_reg;
    logic [lhc_pkg::X_W-1:0]   best_x_reg;
    logic [lhc_pkg::X_W-1:0]   best_d_reg;
    logic [lhc_pkg::X_W-1:0]   dx_abs;
    logic                      take;

    // |dx| and acceptance: wanted layer, free, in window, and strictly nearer than the best so far
    always_comb
    begin
        dx_abs = (cand_x >= qx) ? (cand_x - qx) : (qx - cand_x);
        take = ctrl.sample
            && (cand_layer == want_layer)
            && (cand_label == lhc_pkg::LBL_FREE)
            && ({{(lhc_pkg::LIMIT_W - lhc_pkg::X_W){1'b0}}, dx_abs} <= limit)
            && (!found_reg || (dx_abs < best_d_reg));
    end

    // Found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    // Best candidate payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= cand_idx;
            best_x_reg   <= cand_x;
            best_d_reg   <= dx_abs;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign best_x   = best_x_reg;

endmodule

`default_nettype wire

### rtl/layered_hit_clustering_unit.sv
// Layered hit clustering: hit store, clustering sequencer and label output.
//
// Usage: hits arrive one transaction at a time on hit_valid/hit_ready/hit_data
// and are stored as they arrive; up to 64 hits per event, further hits are
// dropped and the event's overflowed flag is set. The hit with final_hit set
// closes the event: the block then drops hit_ready and clusters the stored
// hits, layer by layer from the top. Every stored hit is visited once per
// layer (read, check, advance). A free seed of layer L also scans all N stored
// hits once per lower layer through one shared compare unit, one hit per
// cycle, then writes one label per hit it labels. Labels then leave in load
// order on lbl_valid/lbl_ready/lbl_data, one transaction per stored hit; each
// is read from the label store, loaded into the output register and taken
// before the next is read. last_label marks the last one. A stall holds the
// label in the output register. After the last label is taken the block
// clears its counters and accepts the next event. Reset sets eps to 2 and
// min_points to 4 and empties the store; no clearing pass is needed. cfg_we
// writes register cfg_idx (0 eps, 1 min_points); the user must write only
// while the block is idle, the block itself does not enforce it.
`default_nettype none

module layered_hit_clustering_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               hit_valid,
    output logic                                    hit_ready,
    input  wire lhc_pkg::hit_in_t                   hit_data,
    output logic                                    lbl_valid,
    input  wire logic                               lbl_ready,
    output lhc_pkg::label_out_t                     lbl_data,
    input  wire logic                               cfg_we,
    input  wire logic [lhc_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  wire logic [lhc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    lhc_pkg::state_t state_reg, state_next;

    logic [lhc_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          dropped_reg, dropped_next;
    logic [lhc_pkg::CNT_W-1:0]     next_cl_reg, next_cl_next;
    logic [lhc_pkg::EPS_W-1:0]     eps_reg;
    logic [lhc_pkg::MINP_W-1:0]    minp_reg;
    logic [lhc_pkg::LAYER_W-1:0]   cur_layer_reg, cur_layer_next;
    logic [lhc_pkg::IDX_W-1:0]     seed_idx_reg, seed_idx_next;
    logic [lhc_pkg::X_W-1:0]       qx_reg, qx_next;
    logic [lhc_pkg::LAYER_W-1:0]   li_reg, li_next;
    logic [lhc_pkg::LIMIT_W-1:0]   limit_reg, limit_next;
    logic [lhc_pkg::CHAIN_W-1:0]   len_reg, len_next;
    logic [lhc_pkg::IDX_W-1:0]     chain_reg [lhc_pkg::CHAIN_DEPTH];
    logic                          chain_we;
    logic [lhc_pkg::CNT_W-1:0]     scan_addr_reg, scan_addr_next;
    logic                          pend_v_reg, pend_v_next;
    logic [lhc_pkg::IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [lhc_pkg::CHAIN_W-1:0]   lab_cnt_reg, lab_cnt_next;
    logic [lhc_pkg::IDX_W-1:0]     out_idx_reg, out_idx_next;
    logic                          out_valid_reg, out_valid_next;
    lhc_pkg::label_out_t           out_data_reg, out_data_next;

    // Memory ports
    logic                           hit_we;
    logic [lhc_pkg::IDX_W-1:0]      hit_waddr;
    logic [lhc_pkg::HIT_W-1:0]      hit_wdata;
    logic [lhc_pkg::HIT_W-1:0]      hit_rdata;
    logic                           lbl_we;
    logic [lhc_pkg::IDX_W-1:0]      lbl_waddr;
    logic [lhc_pkg::LBL_W-1:0]      lbl_wdata;
    logic [lhc_pkg::LBL_W-1:0]      lbl_rdata;
    logic [lhc_pkg::IDX_W-1:0]      rd_addr;

    logic [lhc_pkg::LAYER_W-1:0]    rd_layer;
    logic [lhc_pkg::X_W-1:0]        rd_x;
    logic signed [lhc_pkg::LBL_W-1:0] rd_label;

    lhc_pkg::match_ctrl_t           mctrl;
    logic                           m_found;
    logic [lhc_pkg::IDX_W-1:0]      m_best_idx;
    logic [lhc_pkg::X_W-1:0]        m_best_x;

    logic [lhc_pkg::MINP_W-1:0]     need;
    logic                           is_cluster;
    logic [lhc_pkg::CHAIN_W-1:0]    chain_sel;
    logic                           hit_acc;
    logic                           last_seed;
    logic                           scan_more;

    assign rd_layer = hit_rdata[lhc_pkg::HIT_W-1 -: lhc_pkg::LAYER_W];
    assign rd_x     = hit_rdata[lhc_pkg::X_W-1:0];
    assign rd_label = $signed(lbl_rdata);

    // Hit store: layer and x
    lhc_ram #(
        .WIDTH (lhc_pkg::HIT_W),
        .DEPTH (lhc_pkg::MAX_HITS)
    ) u_hit_ram (
        .clk   (clk),
        .we    (hit_we),
        .waddr (hit_waddr),
        .wdata (hit_wdata),
        .raddr (rd_addr),
        .rdata (hit_rdata)
    );

    // Label store
    lhc_ram #(
        .WIDTH (lhc_pkg::LBL_W),
        .DEPTH (lhc_pkg::MAX_HITS)
    ) u_lbl_ram (
        .clk   (clk),
        .we    (lbl_we),
        .waddr (lbl_waddr),
        .wdata (lbl_wdata),
        .raddr (rd_addr),
        .rdata (lbl_rdata)
    );

    // Shared nearest-hit compare unit; candidate is the hit read last cycle
    lhc_match u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mctrl),
        .cand_idx   (pend_idx_reg),
        .cand_layer (rd_layer),
        .cand_x     (rd_x),
        .cand_label (rd_label),
        .want_layer (li_reg),
        .qx         (qx_reg),
        .limit      (limit_reg),
        .found      (m_found),
        .best_idx   (m_best_idx),
        .best_x     (m_best_x)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= lhc_pkg::EPS_RESET;
            minp_reg <= lhc_pkg::MINP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                lhc_pkg::REG_EPS:        eps_reg  <= cfg_data[lhc_pkg::EPS_W-1:0];
                lhc_pkg::REG_MIN_POINTS: minp_reg <= cfg_data[lhc_pkg::MINP_W-1:0];
                default:                 ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lhc_pkg::ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            next_cl_reg   <= '0;
            cur_layer_reg <= '0;
            seed_idx_reg  <= '0;
            li_reg        <= '0;
            len_reg       <= '0;
            scan_addr_reg <= '0;
            pend_v_reg    <= 1'b0;
            lab_cnt_reg   <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            next_cl_reg   <= next_cl_next;
            cur_layer_reg <= cur_layer_next;
            seed_idx_reg  <= seed_idx_next;
            li_reg        <= li_next;
            len_reg       <= len_next;
            scan_addr_reg <= scan_addr_next;
            pend_v_reg    <= pend_v_next;
            lab_cnt_reg   <= lab_cnt_next;
            out_idx_reg   <= out_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        qx_reg       <= qx_next;
        limit_reg    <= limit_next;
        pend_idx_reg <= pend_idx_next;
        out_data_reg <= out_data_next;
        if (chain_we)
        begin
            chain_reg[len_reg] <= m_best_idx;
        end
    end

    // Sequencer: next state, memory ports and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        next_cl_next   = next_cl_reg;
        cur_layer_next = cur_layer_reg;
        seed_idx_next  = seed_idx_reg;
        qx_next        = qx_reg;
        li_next        = li_reg;
        limit_next     = limit_reg;
        len_next       = len_reg;
        scan_addr_next = scan_addr_reg;
        pend_v_next    = 1'b0;
        pend_idx_next  = scan_addr_reg[lhc_pkg::IDX_W-1:0];
        lab_cnt_next   = lab_cnt_reg;
        out_idx_next   = out_idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        chain_we       = 1'b0;
        mctrl          = '0;

        hit_we    = 1'b0;
        hit_waddr = count_reg[lhc_pkg::IDX_W-1:0];
        hit_wdata = {hit_data.layer, hit_data.xpos};
        lbl_we    = 1'b0;
        lbl_waddr = count_reg[lhc_pkg::IDX_W-1:0];
        lbl_wdata = lhc_pkg::LBL_FREE;
        rd_addr   = seed_idx_reg;

        hit_acc   = hit_valid && (state_reg == lhc_pkg::ST_IDLE);
        last_seed = ({1'b0, seed_idx_reg} + 1'b1) == count_reg;
        scan_more = scan_addr_reg < count_reg;
        need       = (minp_reg == '0) ? '0 : (minp_reg - 1'b1);
        is_cluster = lhc_pkg::MINP_W'(len_reg) >= need;
        chain_sel  = lab_cnt_reg - 1'b1;

        case (state_reg)
            // Load hits until the final one of the event
            lhc_pkg::ST_IDLE:
            begin
                if (hit_acc)
                begin
                    if (count_reg < lhc_pkg::CNT_W'(lhc_pkg::MAX_HITS))
                    begin
                        hit_we     = 1'b1;
                        lbl_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (hit_data.final_hit)
                    begin
                        cur_layer_next = lhc_pkg::LAYER_W'(lhc_pkg::NUM_LAYERS - 1);
                        seed_idx_next  = '0;
                        state_next     = lhc_pkg::ST_SEED_RD;
                    end
                end
            end

            lhc_pkg::ST_SEED_RD:
            begin
                rd_addr    = seed_idx_reg;
                state_next = lhc_pkg::ST_SEED_CHK;
            end

            // Is this hit a free seed of the current layer?
            lhc_pkg::ST_SEED_CHK:
            begin
                if ((rd_layer == cur_layer_reg) && (rd_label == lhc_pkg::LBL_FREE))
                begin
                    qx_next      = rd_x;
                    limit_next   = lhc_pkg::LIMIT_W'(eps_reg);
                    len_next     = '0;
                    lab_cnt_next = '0;
                    if (cur_layer_reg == '0)
                    begin
                        state_next = lhc_pkg::ST_LABEL;
                    end
                    else
                    begin
                        li_next        = cur_layer_reg - 1'b1;
                        scan_addr_next = '0;
                        mctrl.clear    = 1'b1;
                        state_next     = lhc_pkg::ST_SCAN;
                    end
                end
                else
                begin
                    state_next = lhc_pkg::ST_SEED_NEXT;
                end
            end

            // One layer scan: issue a read per cycle, compare the one read before
            lhc_pkg::ST_SCAN:
            begin
                rd_addr      = scan_addr_reg[lhc_pkg::IDX_W-1:0];
                mctrl.sample = pend_v_reg;
                if (scan_more)
                begin
                    pend_v_next    = 1'b1;
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                else if (!pend_v_reg)
                begin
                    if (m_found)
                    begin
                        chain_we   = 1'b1;
                        len_next   = len_reg + 1'b1;
                        qx_next    = m_best_x;
                        limit_next = lhc_pkg::LIMIT_W'(eps_reg);
                    end
                    else
                    begin
                        limit_next = limit_reg + lhc_pkg::LIMIT_W'(eps_reg);
                    end
                    if (li_reg == '0)
                    begin
                        lab_cnt_next = '0;
                        state_next   = lhc_pkg::ST_LABEL;
                    end
                    else
                    begin
                        li_next        = li_reg - 1'b1;
                        scan_addr_next = '0;
                        mctrl.clear    = 1'b1;
                    end
                end
            end

            // Write the seed's label, then, for a cluster, one chain member per cycle
            lhc_pkg::ST_LABEL:
            begin
                lbl_we = 1'b1;
                if (lab_cnt_reg == '0)
                begin
                    lbl_waddr = seed_idx_reg;
                end
                else
                begin
                    lbl_waddr = chain_reg[chain_sel];
                end
                lbl_wdata = is_cluster ? lhc_pkg::LBL_W'(next_cl_reg) : lhc_pkg::LBL_NOISE;
                if (!is_cluster)
                begin
                    state_next = lhc_pkg::ST_SEED_NEXT;
                end
                else if (lab_cnt_reg == len_reg)
                begin
                    next_cl_next = next_cl_reg + 1'b1;
                    state_next   = lhc_pkg::ST_SEED_NEXT;
                end
                else
                begin
                    lab_cnt_next = lab_cnt_reg + 1'b1;
                end
            end

            // Advance to the next seed, or the next lower layer
            lhc_pkg::ST_SEED_NEXT:
            begin
                if (last_seed)
                begin
                    seed_idx_next = '0;
                    if (cur_layer_reg == '0)
                    begin
                        out_idx_next = '0;
                        state_next   = lhc_pkg::ST_OUT_RD;
                    end
                    else
                    begin
                        cur_layer_next = cur_layer_reg - 1'b1;
                        state_next     = lhc_pkg::ST_SEED_RD;
                    end
                end
                else
                begin
                    seed_idx_next = seed_idx_reg + 1'b1;
                    state_next    = lhc_pkg::ST_SEED_RD;
                end
            end

            lhc_pkg::ST_OUT_RD:
            begin
                rd_addr    = out_idx_reg;
                state_next = lhc_pkg::ST_OUT_LOAD;
            end

            // Unlabeled hits (out-of-range layer) report as noise
            lhc_pkg::ST_OUT_LOAD:
            begin
                out_data_next.cluster_label =
                    (rd_label == lhc_pkg::LBL_FREE) ? lhc_pkg::LBL_NOISE : rd_label;
                out_data_next.last_label =
                    ({1'b0, out_idx_reg} + 1'b1) == count_reg;
                out_data_next.overflowed = dropped_reg;
                out_valid_next = 1'b1;
                state_next     = lhc_pkg::ST_OUT_WAIT;
            end

            lhc_pkg::ST_OUT_WAIT:
            begin
                if (lbl_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_data_reg.last_label)
                    begin
                        count_next   = '0;
                        next_cl_next = '0;
                        dropped_next = 1'b0;
                        state_next   = lhc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 1'b1;
                        state_next   = lhc_pkg::ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = lhc_pkg::ST_IDLE;
            end
        endcase
    end

    assign hit_ready = (state_reg == lhc_pkg::ST_IDLE);
    assign lbl_valid = out_valid_reg;
    assign lbl_data  = out_data_reg;

endmodule

`default_nettype wire
